FILE: hdl/plb_pkg.sv
package plb_pkg;

  localparam logic [39:0] CAD_RESET = 40'd50000000;
  localparam int DIV_W = 64;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_TRADE  = 2'd1;
  localparam logic [1:0] KIND_FULL   = 2'd2;

  typedef struct packed {
    logic [62:0]        ts;
    logic               is_trade;
    logic               side_is_bid;
    logic [47:0]        price;
    logic signed [47:0] qty;
    logic               remove;
  } item_t;

  typedef struct packed {
    logic               done;
    logic [DIV_W-1:0]   quot;
    logic [39:0]        rem;
  } div_st_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [62:0]        time_ns;
    logic [31:0]        repeat_count;
    logic [47:0]        bid_price;
    logic [46:0]        bid_size;
    logic [47:0]        ask_price;
    logic [46:0]        ask_size;
    logic               trade_is_bid;
    logic [47:0]        trade_price;
    logic signed [47:0] trade_qty;
    logic               last;
  } res_t;

endpackage

FILE: hdl/price_level_book_with_quote_sampler.sv
// channel  direction  handshake          payload
// in       input      in_valid/in_stall  timestamp, trade flag, side, price, quantity
// out      output     out_valid/out_stall kind, times, top of book, trade echo, last
// cfg      input      cfg_we             sample cadence, 40 bits
//
// An item is popped, then the divider runs when arming or when a sample is due, the level
// tables are scanned for book updates and for samples, and a book update is written back.
// The divider retires one quotient bit per cycle; the scan reads one table entry per cycle.
// Synchronous active-low reset clears control and level used bits at once; no sweep.
// A two-word queue decouples input from processing; a stalled output holds the back end.
module price_level_book_with_quote_sampler import plb_pkg::*; #(
  parameter int LEVELS_PER_SIDE = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [39:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [62:0]        in_timestamp_ns,
  input  logic               in_is_trade,
  input  logic               in_side_is_bid,
  input  logic [47:0]        in_price,
  input  logic signed [47:0] in_quantity,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_kind,
  output logic [62:0]        out_time_ns,
  output logic [31:0]        out_repeat_count,
  output logic [47:0]        out_bid_price,
  output logic [46:0]        out_bid_size,
  output logic [47:0]        out_ask_price,
  output logic [46:0]        out_ask_size,
  output logic               out_trade_is_bid,
  output logic [47:0]        out_trade_price,
  output logic signed [47:0] out_trade_qty,
  output logic               out_last
);

  logic [39:0]      cad_r;
  logic             q_valid, q_pop, div_start;
  item_t            q_item;
  logic [DIV_W-1:0] div_dividend;
  logic [39:0]      div_divisor;
  div_st_t          div_st;
  res_t             res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cad_r <= CAD_RESET;
    end else if (cfg_we) begin
      cad_r <= cfg_wdata;
    end
  end

  plb_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_timestamp_ns (in_timestamp_ns),
    .in_is_trade     (in_is_trade),
    .in_side_is_bid  (in_side_is_bid),
    .in_price        (in_price),
    .in_quantity     (in_quantity),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop)
  );

  plb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .st       (div_st)
  );

  plb_back #(.LEVELS(LEVELS_PER_SIDE)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cad          (cad_r),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_st       (div_st),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_res      (res)
  );

  assign out_kind         = res.kind;
  assign out_time_ns      = res.time_ns;
  assign out_repeat_count = res.repeat_count;
  assign out_bid_price    = res.bid_price;
  assign out_bid_size     = res.bid_size;
  assign out_ask_price    = res.ask_price;
  assign out_ask_size     = res.ask_size;
  assign out_trade_is_bid = res.trade_is_bid;
  assign out_trade_price  = res.trade_price;
  assign out_trade_qty    = res.trade_qty;
  assign out_last         = res.last;

endmodule

FILE: hdl/plb_front.sv
module plb_front import plb_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [62:0]        in_timestamp_ns,
  input  logic               in_is_trade,
  input  logic               in_side_is_bid,
  input  logic [47:0]        in_price,
  input  logic signed [47:0] in_quantity,
  output logic               q_valid,
  output item_t              q_item,
  input  logic               q_pop
);

  item_t      buf_r [2];
  item_t      item_in;
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_item   = buf_r[rp_r];

  always_comb begin
    item_in.ts          = in_timestamp_ns;
    item_in.is_trade    = in_is_trade;
    item_in.side_is_bid = in_side_is_bid;
    item_in.price       = in_price;
    item_in.qty         = in_quantity;
    item_in.remove      = !in_is_trade && ((in_quantity == 48'sd0) || in_quantity[47]);
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: hdl/plb_div.sv
module plb_div import plb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [39:0]      divisor,
  output div_st_t          st
);

  localparam int DCW = $clog2(DIV_W);

  logic [DCW-1:0]   cnt_r;
  logic             busy_r, done_r;
  logic [39:0]      acc_r, dvs_r;
  logic [DIV_W-1:0] dq_r;
  logic [40:0]      trial;
  logic             fits;

  assign trial = {acc_r, dq_r[DIV_W-1]};
  assign fits  = (trial >= {1'b0, dvs_r});

  assign st.done = done_r;
  assign st.quot = dq_r;
  assign st.rem  = acc_r;

  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= dividend;
      acc_r <= 40'd0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      acc_r <= fits ? 40'(trial - {1'b0, dvs_r}) : trial[39:0];
      dq_r  <= {dq_r[DIV_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DCW'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hdl/plb_back.sv
module plb_back import plb_pkg::*; #(
  parameter int LEVELS = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [39:0]      cad,
  input  logic             q_valid,
  input  item_t            q_item,
  output logic             q_pop,
  output logic             div_start,
  output logic [DIV_W-1:0] div_dividend,
  output logic [39:0]      div_divisor,
  input  div_st_t          div_st,
  output logic             out_valid,
  input  logic             out_stall,
  output res_t             out_res
);

  localparam int IW = $clog2(LEVELS);
  localparam int CW = IW + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_EMIT0 = 3'd4;
  localparam logic [2:0] S_EMIT1 = 3'd5;

  logic [2:0]  state_r, state_nxt;
  item_t       item_r;
  logic        armed_r, arm_mode_r, sample_r, full_r;
  logic [31:0] cnt_r;
  logic [63:0] stime_r, next_r;

  logic [47:0] bid_p_mem [LEVELS];
  logic [46:0] bid_s_mem [LEVELS];
  logic [47:0] ask_p_mem [LEVELS];
  logic [46:0] ask_s_mem [LEVELS];
  logic [LEVELS-1:0] bid_used_r, ask_used_r;

  logic [47:0] bp_rd_r, ap_rd_r;
  logic [46:0] bs_rd_r, as_rd_r;
  logic [CW-1:0] scan_cnt_r;
  logic          pv_r;
  logic [IW-1:0] pidx_r;

  logic          bb_found_r, ba_found_r, m_found_r, f_found_r;
  logic [47:0]   bb_p_r, ba_p_r;
  logic [46:0]   bb_s_r, ba_s_r;
  logic [IW-1:0] m_idx_r, f_idx_r;

  logic        out_valid_r;
  res_t        out_res_r;

  logic [39:0] cad_eff;
  logic [63:0] cad64, rem64, ts_in64, ts64;
  logic        ts_reach, scan_start, scan_end, need_scan_div;
  logic        u_b, u_a, tgt_used;
  logic [47:0] tgt_p;
  logic        upd_bb, upd_ba, upd_m, upd_f;
  logic        slot_free, load_res, emit_second;
  res_t        res_nxt;
  logic [31:0] cnt_sat;
  logic        we, ins, del;
  logic [IW-1:0] waddr;

  assign cad_eff  = (cad == 40'd0) ? 40'd1 : cad;
  assign cad64    = {24'd0, cad_eff};
  assign rem64    = {24'd0, div_st.rem};
  assign ts_in64  = {1'b0, q_item.ts};
  assign ts64     = {1'b0, item_r.ts};
  assign ts_reach = (ts_in64 >= next_r);

  assign q_pop        = (state_r == S_IDLE) && q_valid;
  assign div_start    = q_pop && (!armed_r || ts_reach);
  assign div_dividend = armed_r ? (ts_in64 - next_r) : ts_in64;
  assign div_divisor  = cad_eff;

  assign cnt_sat = ((|div_st.quot[63:32]) || (&div_st.quot[31:0])) ? 32'hFFFF_FFFF :
                   (div_st.quot[31:0] + 32'd1);
  assign need_scan_div = !item_r.is_trade || !arm_mode_r || (div_st.rem == 40'd0);

  assign scan_start = (q_pop && !div_start && !q_item.is_trade) ||
                      ((state_r == S_DIV) && div_st.done && need_scan_div);
  assign scan_end   = (state_r == S_SCAN) && (scan_cnt_r == CW'(LEVELS)) && !pv_r;

  assign u_b      = bid_used_r[pidx_r];
  assign u_a      = ask_used_r[pidx_r];
  assign tgt_used = item_r.side_is_bid ? u_b : u_a;
  assign tgt_p    = item_r.side_is_bid ? bp_rd_r : ap_rd_r;
  assign upd_bb   = pv_r && u_b && (!bb_found_r || (bp_rd_r > bb_p_r));
  assign upd_ba   = pv_r && u_a && (!ba_found_r || (ap_rd_r < ba_p_r));
  assign upd_m    = pv_r && tgt_used && (tgt_p == item_r.price) && !m_found_r;
  assign upd_f    = pv_r && !tgt_used && !f_found_r;

  assign del   = (state_r == S_WRITE) && m_found_r && item_r.remove;
  assign ins   = (state_r == S_WRITE) && !m_found_r && !item_r.remove && f_found_r;
  assign we    = (state_r == S_WRITE) && ((m_found_r && !item_r.remove) || ins);
  assign waddr = m_found_r ? m_idx_r : f_idx_r;

  assign slot_free   = !out_valid_r || !out_stall;
  assign emit_second = item_r.is_trade || full_r;
  assign load_res    = slot_free &&
                       (((state_r == S_EMIT0) && sample_r) ||
                        ((state_r == S_EMIT1) && emit_second));

  always_comb begin
    res_nxt = '0;
    if (state_r == S_EMIT0) begin
      res_nxt.kind         = KIND_SAMPLE;
      res_nxt.time_ns      = stime_r[62:0];
      res_nxt.repeat_count = cnt_r;
      res_nxt.bid_price    = bb_p_r;
      res_nxt.bid_size     = bb_s_r;
      res_nxt.ask_price    = ba_p_r;
      res_nxt.ask_size     = ba_s_r;
      res_nxt.last         = !emit_second;
    end else begin
      res_nxt.kind         = item_r.is_trade ? KIND_TRADE : KIND_FULL;
      res_nxt.time_ns      = item_r.ts;
      res_nxt.trade_is_bid = item_r.side_is_bid;
      res_nxt.trade_price  = item_r.price;
      res_nxt.trade_qty    = item_r.qty;
      res_nxt.last         = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          if (div_start) begin
            state_nxt = S_DIV;
          end else if (!q_item.is_trade) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_EMIT0;
          end
        end
      end
      S_DIV: begin
        if (div_st.done) begin
          state_nxt = need_scan_div ? S_SCAN : S_EMIT0;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_nxt = item_r.is_trade ? S_EMIT0 : S_WRITE;
        end
      end
      S_WRITE: state_nxt = S_EMIT0;
      S_EMIT0: begin
        if (!sample_r || load_res) begin
          state_nxt = (sample_r && !emit_second) ? S_IDLE : S_EMIT1;
        end
      end
      S_EMIT1: begin
        if (!emit_second || load_res) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    bp_rd_r <= bid_p_mem[scan_cnt_r[IW-1:0]];
    bs_rd_r <= bid_s_mem[scan_cnt_r[IW-1:0]];
    ap_rd_r <= ask_p_mem[scan_cnt_r[IW-1:0]];
    as_rd_r <= ask_s_mem[scan_cnt_r[IW-1:0]];
    if (we && item_r.side_is_bid) begin
      bid_p_mem[waddr] <= item_r.price;
      bid_s_mem[waddr] <= item_r.qty[46:0];
    end
    if (we && !item_r.side_is_bid) begin
      ask_p_mem[waddr] <= item_r.price;
      ask_s_mem[waddr] <= item_r.qty[46:0];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r   <= q_item;
      sample_r <= 1'b0;
      full_r   <= 1'b0;
      arm_mode_r <= !armed_r;
    end
    if ((state_r == S_DIV) && div_st.done) begin
      if (arm_mode_r) begin
        sample_r <= (div_st.rem == 40'd0);
        cnt_r    <= 32'd1;
        stime_r  <= ts64;
      end else begin
        sample_r <= 1'b1;
        cnt_r    <= cnt_sat;
        stime_r  <= next_r;
      end
    end
    if (scan_start) begin
      bb_found_r <= 1'b0;
      ba_found_r <= 1'b0;
      m_found_r  <= 1'b0;
      f_found_r  <= 1'b0;
      bb_p_r     <= '0;
      bb_s_r     <= '0;
      ba_p_r     <= '0;
      ba_s_r     <= '0;
    end else begin
      if (upd_bb) begin
        bb_found_r <= 1'b1;
        bb_p_r     <= bp_rd_r;
        bb_s_r     <= bs_rd_r;
      end
      if (upd_ba) begin
        ba_found_r <= 1'b1;
        ba_p_r     <= ap_rd_r;
        ba_s_r     <= as_rd_r;
      end
      if (upd_m) begin
        m_found_r <= 1'b1;
        m_idx_r   <= pidx_r;
      end
      if (upd_f) begin
        f_found_r <= 1'b1;
        f_idx_r   <= pidx_r;
      end
    end
    if (state_r == S_WRITE) begin
      full_r <= !m_found_r && !item_r.remove && !f_found_r;
    end
    if (load_res) begin
      out_res_r <= res_nxt;
    end
    pidx_r <= scan_cnt_r[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      armed_r     <= 1'b0;
      next_r      <= 64'd0;
      bid_used_r  <= '0;
      ask_used_r  <= '0;
      scan_cnt_r  <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_DIV) && div_st.done) begin
        armed_r <= 1'b1;
        if (arm_mode_r) begin
          next_r <= ts64 + cad64 - ((div_st.rem == 40'd0) ? 64'd0 : rem64);
        end else begin
          next_r <= ts64 - rem64 + cad64;
        end
      end
      if (scan_start) begin
        scan_cnt_r <= '0;
        pv_r       <= 1'b0;
      end else if ((state_r == S_SCAN) && (scan_cnt_r != CW'(LEVELS))) begin
        scan_cnt_r <= scan_cnt_r + 1'b1;
        pv_r       <= 1'b1;
      end else begin
        pv_r <= 1'b0;
      end
      if (del && item_r.side_is_bid) begin
        bid_used_r[m_idx_r] <= 1'b0;
      end
      if (del && !item_r.side_is_bid) begin
        ask_used_r[m_idx_r] <= 1'b0;
      end
      if (ins && item_r.side_is_bid) begin
        bid_used_r[f_idx_r] <= 1'b1;
      end
      if (ins && !item_r.side_is_bid) begin
        ask_used_r[f_idx_r] <= 1'b1;
      end
      if (load_res) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

`ifndef SYNTHESIS
  a_scan_armed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> armed_r)
    else $error("table scan without armed sampler");
  a_ins_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ins && item_r.side_is_bid) |-> !bid_used_r[f_idx_r])
    else $error("bid insert into used level");
  a_sample_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (load_res && (state_r == S_EMIT0)) |=> (out_res_r.repeat_count != 32'd0))
    else $error("sample word with zero repeat count");
`endif

endmodule

FILE: tb/plb_checker.sv
module plb_checker import plb_pkg::*; #(
  parameter int LEVELS = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [39:0]        cfg_wdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [62:0]        in_timestamp_ns,
  input  logic               in_is_trade,
  input  logic               in_side_is_bid,
  input  logic [47:0]        in_price,
  input  logic signed [47:0] in_quantity,
  input  logic               out_valid,
  input  logic               out_stall,
  input  res_t               out_word,
  output int                 errors,
  output int                 pending,
  output int                 n_items,
  output int                 n_samples,
  output int                 n_trades,
  output int                 n_full
);

  logic [39:0] cadence;
  logic [63:0] next_sample;
  bit          armed;
  logic [47:0] bid_px [LEVELS];
  logic [46:0] bid_sz [LEVELS];
  bit          bid_used [LEVELS];
  logic [47:0] ask_px [LEVELS];
  logic [46:0] ask_sz [LEVELS];
  bit          ask_used [LEVELS];
  res_t        quote_q [$];

  function automatic void best_of_side(input bit bid, output logic [47:0] px,
                                       output logic [46:0] sz);
    bit found;
    found = 0;
    px = '0;
    sz = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (bid ? bid_used[i] : ask_used[i]) begin
        if (!found || (bid ? (bid_px[i] > px) : (ask_px[i] < px))) begin
          px = bid ? bid_px[i] : ask_px[i];
          sz = bid ? bid_sz[i] : ask_sz[i];
          found = 1;
        end
      end
    end
  endfunction

  // returns 0 when a new level finds no free entry
  function automatic bit apply_level(input bit bid, input logic [47:0] px,
                                     input logic [47:0] qty);
    bit drop;
    int free_ix;
    drop = (qty == '0) || qty[47];
    free_ix = -1;
    for (int i = 0; i < LEVELS; i++) begin
      if (bid ? (bid_used[i] && bid_px[i] == px) : (ask_used[i] && ask_px[i] == px)) begin
        if (bid) begin
          if (drop) bid_used[i] = 0; else bid_sz[i] = qty[46:0];
        end else begin
          if (drop) ask_used[i] = 0; else ask_sz[i] = qty[46:0];
        end
        return 1;
      end
      if (!(bid ? bid_used[i] : ask_used[i]) && free_ix < 0) free_ix = i;
    end
    if (drop) return 1;
    if (free_ix < 0) return 0;
    if (bid) begin
      bid_px[free_ix] = px; bid_sz[free_ix] = qty[46:0]; bid_used[free_ix] = 1;
    end else begin
      ask_px[free_ix] = px; ask_sz[free_ix] = qty[46:0]; ask_used[free_ix] = 1;
    end
    return 1;
  endfunction

  function automatic void predict_event(input logic [62:0] ts, input bit trade,
                                        input bit bid, input logic [47:0] px,
                                        input logic [47:0] qty);
    logic [63:0] cad, rem, cnt, ts64;
    res_t rs, rt;
    bit   have_s, have_t;
    have_s = 0;
    rs = '0;
    rt = '0;
    ts64 = {1'b0, ts};
    cad = (cadence == '0) ? 64'd1 : {24'd0, cadence};
    if (!armed) begin
      rem = ts64 % cad;
      next_sample = (rem != 0) ? ts64 + (cad - rem) : ts64;
      armed = 1;
    end
    if (ts64 >= next_sample) begin
      cnt = (ts64 - next_sample) / cad + 64'd1;
      rs.kind = KIND_SAMPLE;
      rs.time_ns = next_sample[62:0];
      rs.repeat_count = (cnt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : cnt[31:0];
      best_of_side(1, rs.bid_price, rs.bid_size);
      best_of_side(0, rs.ask_price, rs.ask_size);
      next_sample = next_sample + cnt * cad;
      have_s = 1;
    end
    have_t = trade || !apply_level(bid, px, qty);
    if (have_t) begin
      rt.kind = trade ? KIND_TRADE : KIND_FULL;
      rt.time_ns = ts;
      rt.trade_is_bid = bid;
      rt.trade_price = px;
      rt.trade_qty = qty;
      rt.last = 1'b1;
    end
    if (have_s) begin
      rs.last = !have_t;
      quote_q = {quote_q, rs};
    end
    if (have_t) quote_q = {quote_q, rt};
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      cadence = CAD_RESET;
      armed = 0;
      next_sample = '0;
      for (int i = 0; i < LEVELS; i++) begin
        bid_used[i] = 0;
        ask_used[i] = 0;
      end
      quote_q.delete();
      errors = 0;
      n_items = 0;
      n_samples = 0;
      n_trades = 0;
      n_full = 0;
    end else begin
      if (cfg_we) cadence = cfg_wdata;
      if (in_valid && !in_stall) begin
        predict_event(in_timestamp_ns, in_is_trade, in_side_is_bid, in_price, in_quantity);
        n_items++;
      end
      if (out_valid && !out_stall) begin
        if (quote_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word %h", out_word);
        end else begin
          if (out_word !== quote_q[0]) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected %h actual %h", quote_q[0], out_word);
          end
          case (quote_q[0].kind)
            KIND_SAMPLE: n_samples++;
            KIND_TRADE:  n_trades++;
            default:     n_full++;
          endcase
          void'(quote_q.pop_front());
        end
      end
    end
    pending = quote_q.size();
  end

endmodule

FILE: tb/testbench.sv
module testbench import plb_pkg::*;;

  localparam int LIMIT = 6000000;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               cfg_we = 0;
  logic [39:0]        cfg_wdata = '0;
  logic               in_valid = 0;
  logic               in_stall;
  logic [62:0]        in_timestamp_ns = '0;
  logic               in_is_trade = 0;
  logic               in_side_is_bid = 0;
  logic [47:0]        in_price = '0;
  logic signed [47:0] in_quantity = '0;
  logic               out_valid;
  logic               out_stall = 0;
  res_t               out_word;
  int                 errors, pending, n_items, n_samples, n_trades, n_full;
  int                 idle_pct = 0;
  int                 stall_pct = 0;
  int                 cycles = 0;
  logic [62:0]        now_ts = '0;
  logic [39:0]        cur_cad = CAD_RESET;

  always #1 clk = ~clk;

  price_level_book_with_quote_sampler i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_timestamp_ns(in_timestamp_ns),
    .in_is_trade(in_is_trade), .in_side_is_bid(in_side_is_bid), .in_price(in_price),
    .in_quantity(in_quantity), .out_valid(out_valid), .out_stall(out_stall),
    .out_kind(out_word.kind), .out_time_ns(out_word.time_ns),
    .out_repeat_count(out_word.repeat_count), .out_bid_price(out_word.bid_price),
    .out_bid_size(out_word.bid_size), .out_ask_price(out_word.ask_price),
    .out_ask_size(out_word.ask_size), .out_trade_is_bid(out_word.trade_is_bid),
    .out_trade_price(out_word.trade_price), .out_trade_qty(out_word.trade_qty),
    .out_last(out_word.last)
  );

  plb_checker i_checker (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_timestamp_ns(in_timestamp_ns),
    .in_is_trade(in_is_trade), .in_side_is_bid(in_side_is_bid), .in_price(in_price),
    .in_quantity(in_quantity), .out_valid(out_valid), .out_stall(out_stall),
    .out_word(out_word), .errors(errors), .pending(pending), .n_items(n_items),
    .n_samples(n_samples), .n_trades(n_trades), .n_full(n_full)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_event(input logic [62:0] ts, input bit trade, input bit bid,
                            input logic [47:0] px, input logic [47:0] qty);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_timestamp_ns <= ts;
    in_is_trade <= trade;
    in_side_is_bid <= bid;
    in_price <= px;
    in_quantity <= qty;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (1500) @(posedge clk);
  endtask

  task automatic write_cadence(input logic [39:0] v);
    drain();
    cfg_we <= 1;
    cfg_wdata <= v;
    cur_cad = v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [62:0] step_ts();
    logic [63:0] cad, d, t;
    int          r;
    cad = (cur_cad == '0) ? 64'd1 : {24'd0, cur_cad};
    r = $urandom_range(99);
    if (r < 8) d = 0;
    else if (r < 12) return (now_ts > 1000) ? now_ts - $urandom_range(1000) : now_ts;
    else if (r < 85) d = rand64() % (cad + cad / 2 + 1);
    else if (r < 95) d = rand64() % (cad * 8 + 1);
    else d = rand64() % 64'h3_0000_0000;
    t = {1'b0, now_ts} + d;
    if (t > 64'h7FFF_FFFF_FFFF_FFFF) t = 64'h7FFF_FFFF_FFFF_FFFF;
    return t[62:0];
  endfunction

  task automatic random_event();
    bit          bid, trade;
    logic [47:0] px, qty;
    int          r;
    now_ts = step_ts();
    bid = 1'($urandom_range(1));
    trade = ($urandom_range(99) < 20);
    r = $urandom_range(99);
    if (r < 75) px = (bid ? 48'd1000 : 48'd1010) + 48'($urandom_range(15));
    else px = 48'(rand64());
    r = $urandom_range(99);
    if (r < 8) qty = '0;
    else if (r < 25) qty = 48'(rand64()) | 48'h8000_0000_0000;
    else if (r < 85) qty = 48'($urandom_range(1, 100000));
    else qty = 48'(rand64());
    send_event(now_ts, trade, bid, px, qty);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: arming at zero, empty book, updates, removals, trades
    send_event(63'd0, 0, 1, 48'd100, 48'd5);
    send_event(63'd10, 0, 0, 48'd200, 48'd7);
    send_event(63'd50000000, 0, 1, 48'd110, 48'd9);
    send_event(63'd50000000, 0, 1, 48'd110, 48'd11);
    send_event(63'd120000000, 1, 1, 48'hFFFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF);
    send_event(63'd120000001, 1, 0, 48'd0, 48'h8000_0000_0000);
    send_event(63'd130000000, 0, 1, 48'd110, 48'd0);
    send_event(63'd130000000, 0, 0, 48'd999, 48'hFFFF_FFFF_FFFF);
    send_event(63'd140000000, 0, 0, 48'hFFFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF);
    send_event(63'd140000000, 0, 1, 48'd0, 48'd1);
    send_event(63'd90000000, 0, 0, 48'd150, 48'd3);
    send_event(63'd200000000, 0, 0, 48'd200, 48'h8000_0000_0000);
    send_event(63'd250000000, 1, 0, 48'd150, 48'd0);
    send_event(63'd250000000, 0, 1, 48'd100, 48'h8000_0000_0001);
    send_event(63'd260000000, 0, 1, 48'd0, 48'd0);
    send_event(63'd400000000, 0, 0, 48'hFFFF_FFFF_FFFF, 48'h8000_0000_0000);
    now_ts = 63'd400000000;

    // fill the bid table past its depth, then empty it
    idle_pct = 0;
    stall_pct = 0;
    for (int i = 0; i < 262; i++) send_event(now_ts, 0, 1, 48'd5000 + i, 48'd1 + i);
    for (int i = 0; i < 262; i++) begin
      if (i == 130) drain();
      send_event(now_ts, 0, 1, 48'd5000 + i, ($urandom_range(1) ? 48'd0 : 48'hFFFF_FFFF_FFFF));
    end
    send_event(now_ts, 0, 0, 48'd150, 48'h8000_0000_0000);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: write_cadence(40'd1);
        2: write_cadence(40'd0);
        3: write_cadence(40'hFF_FFFF_FFFF);
        4: write_cadence(40'd1000);
        5: write_cadence(40'd7);
        default: ;
      endcase
      for (int k = 0; k < 4; k++) begin
        idle_pct = (k == 1 || k == 3) ? ((k == 1) ? 72 : 29) : 0;
        stall_pct = (k == 2) ? 72 : ((k == 3) ? 29 : 0);
        for (int j = 0; j < 44; j++) random_event();
      end
    end

    // late timestamps so the high bits toggle
    write_cadence(40'd123456789);
    now_ts = 63'h7FFF_FF00_0000_0000;
    idle_pct = 29;
    stall_pct = 29;
    for (int j = 0; j < 40; j++) random_event();
    now_ts = 63'h7FFF_FFFF_FFFF_FFF0;
    for (int j = 0; j < 10; j++) random_event();

    drain();
    $display("%0d events accepted, cadences from 0 to 2^40-1, bid table filled past depth",
             n_items);
    $display("%0d samples, %0d trade echoes, %0d dropped updates; %0d errors",
             n_samples, n_trades, n_full, errors);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/plb_pkg.sv
hdl/plb_front.sv
hdl/plb_div.sv
hdl/plb_back.sv
hdl/price_level_book_with_quote_sampler.sv
tb/plb_checker.sv
tb/testbench.sv
